FILE: rtl/pst_pkg.sv
// pst_pkg: shared types, codes and helpers of the probe signature table.
// Used by pst_cell and probe_signature_table_unit; depends on nothing.
`default_nettype none

package pst_pkg;

  // default table depth
  localparam int ENTRIES_DEF = 64;

  // config port geometry: one 32-bit register at byte address 0
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_RETAIN = 1'b0;   // register index, taken from paddr[2]

  // command codes of an input item
  localparam logic CMD_PROBE = 1'b0;
  localparam logic CMD_SCAN  = 1'b1;

  localparam logic [15:0] CAP16 = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } pst_state_t;

  // search record handed from cell to cell (slot indexes travel beside it)
  typedef struct packed {
    logic        go;
    logic        hit;
    logic [15:0] hit_hits;
    logic [15:0] hit_first;
    logic [15:0] old_last;
  } pst_rec_t;

  // update broadcast to every cell (slot index travels beside it)
  typedef struct packed {
    logic        en;
    logic        fresh;
    logic [47:0] addr;
    logic [31:0] hash;
    logic [15:0] scan;
    logic [15:0] hits;
  } pst_upd_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == CAP16) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/probe_signature_table_unit.sv
// probe_signature_table_unit: top level of the probe signature table.
// Depends on pst_pkg and pst_cell.
`default_nettype none

// Keeps up to ENTRIES (station address, signature hash) pairs, one per cell
// of a row of pst_cell instances. Every input transfer yields exactly one
// result transfer. A begin-scan item or a probe with detail recording off or
// a zero hash goes straight from accept to commit. A recorded probe first
// walks the row: a search record is launched into cell 0 and moves one cell
// per clock down the row, picking up a match and the oldest last-seen entry
// on its way; that walk sets the rate. When it leaves the last cell the
// result is committed: the touched cell is written by a broadcast update
// and the result lands in an output register, so the next item can be
// accepted while that result still waits for out_ready. Only the final
// commit stalls on a full output register. No clearing pass after reset:
// unwritten entries are never compared thanks to the fill count. The
// detail-recording enable sits at byte address 0 of the APB-style port;
// write it only while the block is idle.
module probe_signature_table_unit #(
  parameter int ENTRIES = pst_pkg::ENTRIES_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  // configuration port
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [pst_pkg::ADDR_W-1:0]   paddr,
  input  wire [pst_pkg::DATA_W-1:0]   pwdata,
  output logic [pst_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // input channel
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_cmd,
  input  wire [47:0]                  in_station_addr,
  input  wire [31:0]                  in_signature_hash,
  // result channel
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [15:0]                 out_total_probes,
  output logic [15:0]                 out_dropped_entries,
  output logic                        out_stored,
  output logic [5:0]                  out_slot,
  output logic                        out_fresh_entry,
  output logic [15:0]                 out_entry_hits,
  output logic [15:0]                 out_entry_first_scan,
  output logic [15:0]                 out_scan_number
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam logic [FILL_W-1:0] FULL = FILL_W'(ENTRIES);

  // ---------------------------------------------------------------- config
  logic retain_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == pst_pkg::REG_RETAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retain_r <= 1'b0;
    end else if (cfg_wr) begin
      retain_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (psel && (paddr[2] == pst_pkg::REG_RETAIN)) begin
      prdata[0] = retain_r;
    end
  end

  // ---------------------------------------------------------------- control
  pst_pkg::pst_state_t state_r, state_nxt;
  logic in_xfer, detail, chain_done, commit;

  // latched item
  logic        cmd_r;
  logic        detail_r;
  logic [47:0] key_addr_r;
  logic [31:0] key_hash_r;
  logic        launch_r;

  // counters
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [15:0]       scan_r, scan_nxt;
  logic [15:0]       probes_r, probes_nxt;
  logic [15:0]       drops_r, drops_nxt;

  // search result captured off the end of the row
  pst_pkg::pst_rec_t res_r;
  logic [IDX_W-1:0]  res_hit_slot_r, res_old_slot_r;

  // chain wiring
  pst_pkg::pst_rec_t rec   [ENTRIES+1];
  logic [IDX_W-1:0]  hslot [ENTRIES+1];
  logic [IDX_W-1:0]  oslot [ENTRIES+1];
  pst_pkg::pst_upd_t upd;
  logic [IDX_W-1:0]  upd_slot;

  assign in_xfer    = in_valid && in_ready;
  assign detail     = (in_cmd == pst_pkg::CMD_PROBE) && retain_r && (in_signature_hash != '0);
  assign chain_done = rec[ENTRIES].go;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pst_pkg::ST_IDLE: begin
        if (in_xfer) state_nxt = detail ? pst_pkg::ST_WALK : pst_pkg::ST_FIN;
      end
      pst_pkg::ST_WALK: begin
        if (chain_done) state_nxt = pst_pkg::ST_FIN;
      end
      pst_pkg::ST_FIN: begin
        if (commit) state_nxt = pst_pkg::ST_IDLE;
      end
      default: state_nxt = pst_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    case (state_r)
      pst_pkg::ST_IDLE: in_ready = 1'b1;
      pst_pkg::ST_FIN:  commit   = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        commit   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pst_pkg::ST_IDLE;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_xfer && detail;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r      <= in_cmd;
      detail_r   <= detail;
      key_addr_r <= in_station_addr;
      key_hash_r <= in_signature_hash;
    end
    if ((state_r == pst_pkg::ST_WALK) && chain_done) begin
      res_r          <= rec[ENTRIES];
      res_hit_slot_r <= hslot[ENTRIES];
      res_old_slot_r <= oslot[ENTRIES];
    end
  end

  // ---------------------------------------------------------------- cell row
  // fresh record: no hit yet, oldest seen starts at the top scan number 16'hFFFF
  always_comb begin
    rec[0]          = '0;
    rec[0].go       = launch_r;
    rec[0].old_last = pst_pkg::CAP16;
    hslot[0]        = '0;
    oslot[0]        = '0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pst_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .key_addr   (key_addr_r),
      .key_hash   (key_hash_r),
      .fill       (fill_r),
      .rec_i      (rec[g]),
      .hit_slot_i (hslot[g]),
      .old_slot_i (oslot[g]),
      .rec_o      (rec[g+1]),
      .hit_slot_o (hslot[g+1]),
      .old_slot_o (oslot[g+1]),
      .upd        (upd),
      .upd_slot   (upd_slot)
    );
  end

  // ---------------------------------------------------------------- commit
  logic        stored, fresh;
  logic [15:0] hits_new, first_new;
  logic [31:0] slot_ext;

  always_comb begin
    scan_nxt   = scan_r;
    probes_nxt = probes_r;
    drops_nxt  = drops_r;
    fill_nxt   = fill_r;
    stored     = 1'b0;
    fresh      = 1'b0;
    upd_slot   = '0;
    hits_new   = '0;
    first_new  = '0;
    if (cmd_r == pst_pkg::CMD_SCAN) begin
      scan_nxt = scan_r + 16'd1;
    end else begin
      probes_nxt = pst_pkg::sat_inc16(probes_r);
      if (detail_r) begin
        stored = 1'b1;
        if (res_r.hit) begin
          upd_slot  = res_hit_slot_r;
          hits_new  = pst_pkg::sat_inc16(res_r.hit_hits);
          first_new = res_r.hit_first;
        end else begin
          fresh     = 1'b1;
          hits_new  = 16'd1;
          first_new = scan_r;
          if (fill_r < FULL) begin
            upd_slot = fill_r[IDX_W-1:0];
            fill_nxt = fill_r + FILL_W'(1);
          end else begin
            // table full: replace the least recently seen entry
            upd_slot  = res_old_slot_r;
            drops_nxt = pst_pkg::sat_inc16(drops_r);
          end
        end
      end
    end
  end

  assign slot_ext = 32'(upd_slot);

  always_comb begin
    upd       = '0;
    upd.en    = commit && stored;
    upd.fresh = fresh;
    upd.addr  = key_addr_r;
    upd.hash  = key_hash_r;
    upd.scan  = scan_r;
    upd.hits  = hits_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      scan_r    <= '0;
      probes_r  <= '0;
      drops_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        fill_r   <= fill_nxt;
        scan_r   <= scan_nxt;
        probes_r <= probes_nxt;
        drops_r  <= drops_nxt;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_total_probes     <= probes_nxt;
      out_dropped_entries  <= drops_nxt;
      out_stored           <= stored;
      out_slot             <= stored ? slot_ext[5:0] : 6'd0;
      out_fresh_entry      <= fresh;
      out_entry_hits       <= hits_new;
      out_entry_first_scan <= first_new;
      out_scan_number      <= scan_nxt;
    end
  end

  // ---------------------------------------------------------------- checks
  a_launch_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r |-> (state_r == pst_pkg::ST_WALK))
    else $error("search launched outside walk");

  a_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    chain_done |-> (state_r == pst_pkg::ST_WALK))
    else $error("search record left the row outside walk");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count beyond table depth");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (drops_nxt != drops_r)) |-> (fill_r == FULL))
    else $error("eviction while table not full");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("pending result overwritten or lost");

endmodule

`default_nettype wire

FILE: rtl/pst_cell.sv
// pst_cell: one table entry plus one stage of the search record chain.
// Depends on pst_pkg (record and update structs).
`default_nettype none

module pst_cell #(
  parameter int ENTRIES = pst_pkg::ENTRIES_DEF,
  parameter int IDX     = 0
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [47:0]                   key_addr,
  input  wire [31:0]                   key_hash,
  input  wire [$clog2(ENTRIES+1)-1:0]  fill,
  input  pst_pkg::pst_rec_t            rec_i,
  input  wire [$clog2(ENTRIES)-1:0]    hit_slot_i,
  input  wire [$clog2(ENTRIES)-1:0]    old_slot_i,
  output pst_pkg::pst_rec_t            rec_o,
  output logic [$clog2(ENTRIES)-1:0]   hit_slot_o,
  output logic [$clog2(ENTRIES)-1:0]   old_slot_o,
  input  pst_pkg::pst_upd_t            upd,
  input  wire [$clog2(ENTRIES)-1:0]    upd_slot
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0]  MY_SLOT = IDX_W'(IDX);
  localparam logic [FILL_W-1:0] MY_FILL = FILL_W'(IDX);

  // entry storage, undefined until first written
  logic [47:0] addr_r;
  logic [31:0] hash_r;
  logic [15:0] first_r;
  logic [15:0] last_r;
  logic [15:0] hits_r;

  pst_pkg::pst_rec_t     rec_nxt, rec_r;
  logic [IDX_W-1:0]      hit_slot_nxt, hit_slot_r;
  logic [IDX_W-1:0]      old_slot_nxt, old_slot_r;
  logic                  filled, match, older, wr;

  assign filled = MY_FILL < fill;
  assign match  = rec_i.go && filled && !rec_i.hit &&
                  (addr_r == key_addr) && (hash_r == key_hash);
  assign older  = rec_i.go && filled && (last_r < rec_i.old_last);
  assign wr     = upd.en && (upd_slot == MY_SLOT);

  always_comb begin
    rec_nxt      = rec_i;
    hit_slot_nxt = hit_slot_i;
    old_slot_nxt = old_slot_i;
    if (match) begin
      rec_nxt.hit       = 1'b1;
      rec_nxt.hit_hits  = hits_r;
      rec_nxt.hit_first = first_r;
      hit_slot_nxt      = MY_SLOT;
    end
    if (older) begin
      rec_nxt.old_last = last_r;
      old_slot_nxt     = MY_SLOT;
    end
  end

  // only the go flag needs a reset; the rest follows it through the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.go <= 1'b0;
    end else begin
      rec_r.go <= rec_nxt.go;
    end
    rec_r.hit       <= rec_nxt.hit;
    rec_r.hit_hits  <= rec_nxt.hit_hits;
    rec_r.hit_first <= rec_nxt.hit_first;
    rec_r.old_last  <= rec_nxt.old_last;
    hit_slot_r      <= hit_slot_nxt;
    old_slot_r      <= old_slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      if (upd.fresh) begin
        addr_r  <= upd.addr;
        hash_r  <= upd.hash;
        first_r <= upd.scan;
      end
      last_r <= upd.scan;
      hits_r <= upd.hits;
    end
  end

  assign rec_o      = rec_r;
  assign hit_slot_o = hit_slot_r;
  assign old_slot_o = old_slot_r;

endmodule

`default_nettype wire
